@@ rtl/nial_pkg.sv @@
// package: constants, command and status codes, word types and fsm states for the adjacency store
package nial_pkg;
    localparam int NODES = 1024;
    localparam int POOL = 4096;
    localparam int NW = 11;
    localparam int NAW = 10;
    localparam int EW = 13;
    localparam int EAW = 12;
    localparam int IW = 31;
    localparam logic [EW-1:0] NIL = EW'(POOL);

    localparam logic [2:0] MD_ADD = 3'd0;
    localparam logic [2:0] MD_REMOVE = 3'd1;
    localparam logic [2:0] MD_EXISTS = 3'd2;
    localparam logic [2:0] MD_DEGREE = 3'd3;
    localparam logic [2:0] MD_RESIZE = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [10:0] node;
        logic [30:0] item;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [12:0] degree;
    } t_out_word;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HEAD, S_ADD, S_WALK, S_UNLINK, S_RSZ_HEAD, S_RSZ_POP, S_RSZ_CLR,
        S_DONE
    } t_state;
endpackage

@@ rtl/node_item_adjacency_lists.sv @@
// node_item_adjacency_lists: per-node linked lists of items held in a shared entry pool
// Each node keeps a singly linked list whose entries come from a pool of 4096 entries; free
// entries form a chain of their own. After reset the block runs a clearing pass that links
// the pool and empties every list head, and accepts no word until it ends. Each word then
// starts with a head read, and every step of a list walk is a read of the entry memory: add
// links the first free entry in front of the list; remove, exists and degree walk the list
// (remove then unlinks the matching entry); a shrinking resize pops the entries of every
// dropped node onto the free chain, and a growing resize empties the new list heads. One word is
// in work at a time; the result sits in an output register and the next word is taken once it
// has been passed on.
module node_item_adjacency_lists (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  nial_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output nial_pkg::t_out_word  o_data
);
    logic [nial_pkg::EW-1:0] head_mem [nial_pkg::NODES];
    logic [nial_pkg::EW-1:0] next_mem [nial_pkg::POOL];
    logic [nial_pkg::IW-1:0] item_mem [nial_pkg::POOL];

    nial_pkg::t_state r_state, n_state;
    nial_pkg::t_in_word r_cmd, n_cmd;
    logic [nial_pkg::EW-1:0] r_cnt, n_cnt;
    logic [nial_pkg::EW-1:0] r_cur, n_cur;
    logic [nial_pkg::EW-1:0] r_prev, n_prev;
    logic [nial_pkg::EW-1:0] r_free, n_free;
    logic [nial_pkg::NW-1:0] r_ncount, n_ncount;
    logic [nial_pkg::NW-1:0] r_rn, n_rn;
    logic [nial_pkg::NW-1:0] r_want, n_want;
    logic r_ovalid, n_ovalid;
    nial_pkg::t_out_word r_out, n_out;

    logic [nial_pkg::EW-1:0] r_head_rd, r_next_rd;
    logic [nial_pkg::IW-1:0] r_item_rd;

    logic                    h_re, h_we, e_re, nx_we, it_we;
    logic [nial_pkg::NAW-1:0] h_ra, h_wa;
    logic [nial_pkg::EW-1:0] h_wd, nx_wd;
    logic [nial_pkg::EAW-1:0] e_ra, nx_wa, it_wa;
    logic [nial_pkg::IW-1:0] it_wd;
    logic accept;
    logic cur_ok;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != nial_pkg::S_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (h_we) head_mem[h_wa] <= h_wd;
        if (h_re) r_head_rd <= head_mem[h_ra];
        if (nx_we) next_mem[nx_wa] <= nx_wd;
        if (it_we) item_mem[it_wa] <= it_wd;
        if (e_re) begin
            r_next_rd <= next_mem[e_ra];
            r_item_rd <= item_mem[e_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nial_pkg::S_INIT;
            r_cnt <= '0;
            r_free <= '0;
            r_ncount <= nial_pkg::NW'(nial_pkg::NODES);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_free <= n_free;
            r_ncount <= n_ncount;
            r_ovalid <= n_ovalid;
        end
        r_cmd <= n_cmd;
        r_cur <= n_cur;
        r_prev <= n_prev;
        r_rn <= n_rn;
        r_want <= n_want;
        r_out <= n_out;
    end

    assign cur_ok = r_cur < nial_pkg::NIL;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nial_pkg::S_INIT:
                if (r_cnt == nial_pkg::NIL - 1'b1) n_state = nial_pkg::S_IDLE;
            nial_pkg::S_IDLE: if (accept) begin
                if (i_data.mode <= nial_pkg::MD_DEGREE
                    && i_data.node >= r_ncount) n_state = nial_pkg::S_DONE;
                else if (i_data.mode == nial_pkg::MD_ADD)
                    n_state = (r_free < nial_pkg::NIL) ? nial_pkg::S_HEAD : nial_pkg::S_DONE;
                else if (i_data.mode == nial_pkg::MD_RESIZE) n_state = nial_pkg::S_RSZ_HEAD;
                else if (i_data.mode > nial_pkg::MD_RESIZE) n_state = nial_pkg::S_DONE;
                else n_state = nial_pkg::S_HEAD;
            end
            nial_pkg::S_HEAD:
                n_state = (r_cmd.mode == nial_pkg::MD_ADD) ? nial_pkg::S_ADD : nial_pkg::S_WALK;
            nial_pkg::S_ADD: n_state = nial_pkg::S_DONE;
            nial_pkg::S_WALK:
                if (!cur_ok || r_cnt == nial_pkg::NIL) n_state = nial_pkg::S_DONE;
                else if (r_cmd.mode != nial_pkg::MD_DEGREE && r_item_rd == r_cmd.item)
                    n_state = (r_cmd.mode == nial_pkg::MD_REMOVE) ? nial_pkg::S_UNLINK
                                                                 : nial_pkg::S_DONE;
            nial_pkg::S_UNLINK: n_state = nial_pkg::S_DONE;
            nial_pkg::S_RSZ_HEAD:
                if (r_rn >= r_ncount || r_rn >= nial_pkg::NW'(nial_pkg::NODES))
                    n_state = nial_pkg::S_RSZ_CLR;
                else n_state = nial_pkg::S_RSZ_POP;
            nial_pkg::S_RSZ_POP:
                if (!cur_ok || r_cnt == nial_pkg::NIL) n_state = nial_pkg::S_RSZ_HEAD;
            nial_pkg::S_RSZ_CLR:
                if (r_rn >= r_want) n_state = nial_pkg::S_DONE;
            nial_pkg::S_DONE: n_state = nial_pkg::S_IDLE;
            default: n_state = nial_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd; n_cnt = r_cnt; n_cur = r_cur; n_prev = r_prev; n_free = r_free;
        n_ncount = r_ncount; n_rn = r_rn; n_want = r_want; n_out = r_out;
        n_ovalid = r_ovalid && i_stall;
        h_re = 1'b0; h_we = 1'b0; e_re = 1'b0; nx_we = 1'b0; it_we = 1'b0;
        h_ra = r_cmd.node[nial_pkg::NAW-1:0]; h_wa = r_cmd.node[nial_pkg::NAW-1:0];
        h_wd = nial_pkg::NIL;
        e_ra = r_cur[nial_pkg::EAW-1:0]; nx_wa = r_cur[nial_pkg::EAW-1:0];
        nx_wd = r_next_rd; it_wa = r_cur[nial_pkg::EAW-1:0]; it_wd = '0;
        case (r_state)
            nial_pkg::S_INIT: begin
                nx_we = 1'b1; nx_wa = r_cnt[nial_pkg::EAW-1:0]; nx_wd = r_cnt + 1'b1;
                if (r_cnt < nial_pkg::EW'(nial_pkg::NODES)) begin
                    h_we = 1'b1; h_wa = r_cnt[nial_pkg::NAW-1:0];
                end
                n_cnt = r_cnt + 1'b1;
            end
            nial_pkg::S_IDLE: if (accept) begin
                n_cmd = i_data; n_out = '0; n_cnt = '0; n_prev = nial_pkg::NIL;
                h_re = 1'b1; h_ra = i_data.node[nial_pkg::NAW-1:0];
                e_re = 1'b1; e_ra = r_free[nial_pkg::EAW-1:0]; n_cur = r_free;
                if (i_data.mode <= nial_pkg::MD_DEGREE && i_data.node >= r_ncount)
                    n_out.status = nial_pkg::ST_RANGE;
                else if (i_data.mode == nial_pkg::MD_ADD && r_free >= nial_pkg::NIL)
                    n_out.status = nial_pkg::ST_FULL;
                if (i_data.mode == nial_pkg::MD_RESIZE) begin
                    n_want = (i_data.node == '0) ? nial_pkg::NW'(1)
                           : (i_data.node > nial_pkg::NW'(nial_pkg::NODES))
                             ? nial_pkg::NW'(nial_pkg::NODES) : i_data.node;
                    n_rn = n_want;
                    h_ra = n_want[nial_pkg::NAW-1:0];
                end
            end
            nial_pkg::S_HEAD: begin
                if (r_cmd.mode == nial_pkg::MD_ADD) begin
                    nx_we = 1'b1; nx_wa = r_free[nial_pkg::EAW-1:0]; nx_wd = r_head_rd;
                    it_we = 1'b1; it_wa = r_free[nial_pkg::EAW-1:0]; it_wd = r_cmd.item;
                    h_we = 1'b1; h_wd = r_free;
                    n_free = r_next_rd;
                end else begin
                    n_cur = r_head_rd; e_re = 1'b1; e_ra = r_head_rd[nial_pkg::EAW-1:0];
                end
            end
            nial_pkg::S_WALK: begin
                if (!cur_ok || r_cnt == nial_pkg::NIL) begin
                    if (r_cmd.mode == nial_pkg::MD_REMOVE) n_out.status = nial_pkg::ST_MISSING;
                    if (r_cmd.mode == nial_pkg::MD_DEGREE) n_out.degree = r_cnt;
                end else if (r_cmd.mode != nial_pkg::MD_DEGREE && r_item_rd == r_cmd.item) begin
                    if (r_cmd.mode == nial_pkg::MD_EXISTS) n_out.found = 1'b1;
                    else begin
                        if (r_prev < nial_pkg::NIL) begin
                            nx_we = 1'b1; nx_wa = r_prev[nial_pkg::EAW-1:0];
                        end else begin
                            h_we = 1'b1; h_wd = r_next_rd;
                        end
                    end
                end else begin
                    n_prev = r_cur; n_cur = r_next_rd; n_cnt = r_cnt + 1'b1;
                    e_re = 1'b1; e_ra = r_next_rd[nial_pkg::EAW-1:0];
                end
            end
            nial_pkg::S_UNLINK: begin
                nx_we = 1'b1; nx_wd = r_free; it_we = 1'b1; n_free = r_cur;
            end
            nial_pkg::S_RSZ_HEAD: begin
                n_cur = r_head_rd; n_cnt = '0;
                e_re = 1'b1; e_ra = r_head_rd[nial_pkg::EAW-1:0];
                if (r_rn >= r_ncount || r_rn >= nial_pkg::NW'(nial_pkg::NODES))
                    n_rn = r_ncount;
            end
            nial_pkg::S_RSZ_POP: begin
                if (!cur_ok || r_cnt == nial_pkg::NIL) begin
                    h_we = 1'b1; h_wa = r_rn[nial_pkg::NAW-1:0];
                    n_rn = r_rn + 1'b1;
                    h_re = 1'b1; h_ra = n_rn[nial_pkg::NAW-1:0];
                end else begin
                    nx_we = 1'b1; nx_wd = r_free; it_we = 1'b1; n_free = r_cur;
                    n_cur = r_next_rd; n_cnt = r_cnt + 1'b1;
                    e_re = 1'b1; e_ra = r_next_rd[nial_pkg::EAW-1:0];
                end
            end
            nial_pkg::S_RSZ_CLR: begin
                if (r_rn >= r_want) n_ncount = r_want;
                else begin
                    h_we = 1'b1; h_wa = r_rn[nial_pkg::NAW-1:0]; n_rn = r_rn + 1'b1;
                end
            end
            nial_pkg::S_DONE: n_ovalid = 1'b1;
            default: ;
        endcase
    end
endmodule

@@ rtl/nial_checker.sv @@
// nial_checker: port-level checks for the adjacency store, bound to the top level
module nial_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input nial_pkg::t_in_word  i_data,
    input logic                o_valid,
    input logic                i_stall,
    input nial_pkg::t_out_word o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("result word dropped");
    a_found_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.found |-> o_data.status == nial_pkg::ST_OK
            && o_data.degree == '0) else $error("found with other fields");
    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.degree <= 13'(nial_pkg::POOL)) else $error("degree beyond pool");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("second word taken while busy");
endmodule

bind node_item_adjacency_lists nial_checker u_nial_checker (.*);
